// ----- rtl/fps_pkg.sv -----
// ---------------------------------------------------------------------------
// fps_pkg: shared types and constants
// number formats, register indexes and cordic table of the pixel to sphere unit
// ---------------------------------------------------------------------------
`default_nettype none

package fps_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_AFFINE_C     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AFFINE_D     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AFFINE_E     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_CENTER = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POLY_A0      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POLY_A2      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POLY_A3      = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_POLY_A4      = 4'd7;

  localparam logic [31:0] AFFINE_C_RESET = 32'h4000_0000;

  // image size defaults
  localparam int IMG_ROWS_DEF = 2048;
  localparam int IMG_COLS_DEF = 2048;

  // pixel field widths
  localparam int COORD_W = 12;
  localparam int COLOR_W = 8;
  localparam int THETA_W = 22;
  localparam int PHI_W   = 23;

  // radius datapath
  localparam int R2_W        = 61;
  localparam int R_W         = 31;
  localparam int SQRT_STAGES = R_W;

  // saturation bound of the polynomial
  localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int MUL_LAT = 4;

  // cordic
  localparam int CORDIC_STEPS = 25;
  localparam int NORM_STEPS   = 6;
  localparam int NORM_MSB     = 38;
  localparam int CORDIC_LAT   = NORM_STEPS + 1 + CORDIC_STEPS + 1;
  localparam int HALF_PI_Q24  = 26353589;
  localparam int PI_Q20       = 3294199;

  localparam logic [23:0] ATAN_TAB [CORDIC_STEPS] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214,
    24'd524117, 24'd262123, 24'd131069, 24'd65536, 24'd32768,
    24'd16384, 24'd8192, 24'd4096, 24'd2048, 24'd1024,
    24'd512, 24'd256, 24'd128, 24'd64, 24'd32,
    24'd16, 24'd8, 24'd4, 24'd2, 24'd1
  };

  // pixel data that rides along the pipeline
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } side_t;

endpackage

`default_nettype wire

// ----- rtl/fps_if.sv -----
// ---------------------------------------------------------------------------
// fps_if: stream channels
// pixel input channel and sphere result channel, valid/ready
// ---------------------------------------------------------------------------
`default_nettype none

interface fps_pix_if import fps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pix_row;
  logic [COORD_W-1:0] pix_col;
  logic [COLOR_W-1:0] in_blue;
  logic [COLOR_W-1:0] in_green;
  logic [COLOR_W-1:0] in_red;

  modport source (output valid, pix_row, pix_col, in_blue, in_green, in_red,
                  input ready);
  modport sink (input valid, pix_row, pix_col, in_blue, in_green, in_red,
                output ready);
endinterface

interface fps_sph_if import fps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [THETA_W-1:0] polar_theta;
  logic signed [PHI_W-1:0]   azimuth_phi;
  logic        [COORD_W-1:0] out_row;
  logic        [COORD_W-1:0] out_col;
  logic        [COLOR_W-1:0] out_blue;
  logic        [COLOR_W-1:0] out_green;
  logic        [COLOR_W-1:0] out_red;

  modport source (output valid, polar_theta, azimuth_phi, out_row, out_col,
                  out_blue, out_green, out_red, input ready);
  modport sink (input valid, polar_theta, azimuth_phi, out_row, out_col,
                out_blue, out_green, out_red, output ready);
endinterface

`default_nettype wire

// ----- rtl/fisheye_pixel_to_sphere_unit.sv -----
// ---------------------------------------------------------------------------
// fisheye_pixel_to_sphere_unit: fisheye pixel to unit sphere angles
// affine sensor correction, radius, polynomial z and two cordic angles
// ---------------------------------------------------------------------------
//
//   channel   dir  handshake      carries
//   pix_in    in   valid/ready    pix_row, pix_col, in_blue, in_green, in_red
//   sph_out   out  valid/ready    polar_theta, azimuth_phi, pixel passed through
//   cfg       in   cfg_we only    cfg_index, cfg_data (64b)
//
// one pixel per clock while the output is not held; a result passes through
// the 31-stage square root, two chained multipliers and the
// 33-stage cordic
// synchronous reset clears valid bits and loads the register defaults
// the whole pipeline freezes while the output holds an untaken result;
// a pixel outside the image or with zero radius drops out as a bubble
// ---------------------------------------------------------------------------
`default_nettype none

module fisheye_pixel_to_sphere_unit import fps_pkg::*; #(
  parameter int IMG_ROWS = IMG_ROWS_DEF,
  parameter int IMG_COLS = IMG_COLS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  fps_pix_if.sink                    pix_in,
  fps_sph_if.source                  sph_out
);

  // ---------------- configuration registers ----------------
  logic signed [31:0] affine_c, affine_d, affine_e, poly_a0;
  logic        [63:0] image_center;
  logic signed [63:0] poly_a2, poly_a3, poly_a4;

  always_ff @(posedge clk) begin
    if (rst) begin
      affine_c     <= AFFINE_C_RESET;
      affine_d     <= '0;
      affine_e     <= '0;
      image_center <= '0;
      poly_a0      <= '0;
      poly_a2      <= '0;
      poly_a3      <= '0;
      poly_a4      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AFFINE_C:     affine_c     <= cfg_data[31:0];
        REG_AFFINE_D:     affine_d     <= cfg_data[31:0];
        REG_AFFINE_E:     affine_e     <= cfg_data[31:0];
        REG_IMAGE_CENTER: image_center <= cfg_data;
        REG_POLY_A0:      poly_a0      <= cfg_data[31:0];
        REG_POLY_A2:      poly_a2      <= cfg_data;
        REG_POLY_A3:      poly_a3      <= cfg_data;
        REG_POLY_A4:      poly_a4      <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  // one enable for every stage; output register drains or holds
  logic adv, take, out_vld;
  assign adv          = !out_vld || sph_out.ready;
  assign pix_in.ready = adv;
  assign take         = pix_in.valid && adv;

  // saturating add at +-(2^63-1)
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(SAT_MAX)) begin
      return SAT_MAX;
    end else if (s < -65'(SAT_MAX)) begin
      return -SAT_MAX;
    end
    return 64'(s);
  endfunction

  // ---------------- front end: affine, round, radius squared ----------------
  logic                 v1, v2, v3, v4, v5, v6;
  side_t                side1;
  logic [COORD_W-1:0]   col2;
  logic signed [43:0]   cu, dv, eu;
  logic signed [47:0]   x30, y30;
  logic signed [30:0]   x12, y12;
  logic        [29:0]   ax, ay;
  logic        [59:0]   sqx, sqy;
  logic        [R2_W-1:0] r2_6, r2_next;
  logic                 in_range;

  assign in_range = ({1'b0, pix_in.pix_row} < 13'(IMG_ROWS)) &&
                    ({1'b0, pix_in.pix_col} < 13'(IMG_COLS));
  assign ax      = 30'(x12[30] ? -x12 : x12);
  assign ay      = 30'(y12[30] ? -y12 : y12);
  assign r2_next = R2_W'(sqx) + R2_W'(sqy);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v1 <= take && in_range;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      // zero radius gives no result
      v6 <= v5 && (r2_next != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side1 <= '{row: pix_in.pix_row, col: pix_in.pix_col, blue: pix_in.in_blue,
                 green: pix_in.in_green, red: pix_in.in_red};
      // gains times pixel position
      cu   <= affine_c * $signed({1'b0, side1.row});
      dv   <= affine_d * $signed({1'b0, side1.col});
      eu   <= affine_e * $signed({1'b0, side1.row});
      col2 <= side1.col;
      // x, y in q.30
      x30 <= 48'(cu) + 48'(dv) - $signed({2'b0, image_center[63:32], 14'b0});
      y30 <= 48'(eu) + $signed({6'b0, col2, 30'b0}) -
             $signed({2'b0, image_center[31:0], 14'b0});
      // round to q.12
      x12 <= 31'((x30 + 48'sd131072) >>> 18);
      y12 <= 31'((y30 + 48'sd131072) >>> 18);
      sqx <= ax * ax;
      sqy <= ay * ay;
      r2_6 <= r2_next;
    end
  end

  // ---------------- square root ----------------
  logic            v37;
  logic [R_W-1:0]  r37;
  logic [R2_W-1:0] r2_37, r2_41;

  fps_sqrt u_sqrt (.clk(clk), .en(adv), .r2(r2_6), .r(r37));

  fps_delay #(.W(1), .DEPTH(SQRT_STAGES)) u_dly_v37 (
    .clk(clk), .rst(rst), .en(adv), .d(v6), .q(v37));
  fps_delay #(.W(R2_W), .DEPTH(SQRT_STAGES)) u_dly_r2a (
    .clk(clk), .rst(rst), .en(adv), .d(r2_6), .q(r2_37));
  fps_delay #(.W(R2_W), .DEPTH(MUL_LAT)) u_dly_r2b (
    .clk(clk), .rst(rst), .en(adv), .d(r2_37), .q(r2_41));

  // ---------------- polynomial ----------------
  // first rank: a2*r2, a3*r, a4*r2; second rank: s3*r2, s4*r2
  logic signed [63:0] t2, s3, s4, t3, t4, t2_45;
  logic signed [63:0] t3_46, t4_46, t4_47, z1, z2, z48;

  fps_mulsh #(.SHIFT(56)) u_mul_a2 (
    .clk(clk), .en(adv), .a(poly_a2), .b($signed({3'b0, r2_37})), .p(t2));
  fps_mulsh #(.SHIFT(28)) u_mul_a3 (
    .clk(clk), .en(adv), .a(poly_a3), .b($signed({33'b0, r37})), .p(s3));
  fps_mulsh #(.SHIFT(47)) u_mul_a4 (
    .clk(clk), .en(adv), .a(poly_a4), .b($signed({3'b0, r2_37})), .p(s4));
  fps_mulsh #(.SHIFT(48)) u_mul_s3 (
    .clk(clk), .en(adv), .a(s3), .b($signed({3'b0, r2_41})), .p(t3));
  fps_mulsh #(.SHIFT(48)) u_mul_s4 (
    .clk(clk), .en(adv), .a(s4), .b($signed({3'b0, r2_41})), .p(t4));

  fps_delay #(.W(64), .DEPTH(MUL_LAT)) u_dly_t2 (
    .clk(clk), .rst(rst), .en(adv), .d(t2), .q(t2_45));

  // saturating sum, one term per stage in model order
  always_ff @(posedge clk) begin
    if (adv) begin
      z1    <= sat_add(64'(poly_a0), t2_45);
      t3_46 <= t3;
      t4_46 <= t4;
      z2    <= sat_add(z1, t3_46);
      t4_47 <= t4_46;
      z48   <= sat_add(z2, t4_47);
    end
  end

  // ---------------- angles ----------------
  localparam int D_R  = 2 * MUL_LAT + 3;
  localparam int D_XY = 2 + SQRT_STAGES + D_R;

  logic [R_W-1:0]     r48;
  logic [61:0]        xy48;
  logic signed [PHI_W-1:0] theta_a, phi_a;

  fps_delay #(.W(R_W), .DEPTH(D_R)) u_dly_r (
    .clk(clk), .rst(rst), .en(adv), .d(r37), .q(r48));
  fps_delay #(.W(62), .DEPTH(D_XY)) u_dly_xy (
    .clk(clk), .rst(rst), .en(adv), .d({x12, y12}), .q(xy48));

  // theta = atan2(r, z) with r moved to q.16
  fps_cordic #(.SIGNED_OUT(1'b0)) u_cordic_theta (
    .clk(clk), .en(adv), .x_in(z48), .y_in($signed({29'b0, r48, 4'b0})),
    .ang(theta_a));

  // phi = atan2(y, x) at q.12
  fps_cordic #(.SIGNED_OUT(1'b1)) u_cordic_phi (
    .clk(clk), .en(adv), .x_in(64'($signed(xy48[61:31]))),
    .y_in(64'($signed(xy48[30:0]))), .ang(phi_a));

  // ---------------- output ----------------
  side_t side_o;

  fps_delay #(.W(1), .DEPTH(D_R + CORDIC_LAT)) u_dly_vo (
    .clk(clk), .rst(rst), .en(adv), .d(v37), .q(out_vld));
  fps_delay #(.W($bits(side_t)), .DEPTH(D_XY + 3 + CORDIC_LAT)) u_dly_side (
    .clk(clk), .rst(rst), .en(adv), .d(side1), .q(side_o));

  assign sph_out.valid       = out_vld;
  assign sph_out.polar_theta = theta_a[THETA_W-1:0];
  assign sph_out.azimuth_phi = phi_a;
  assign sph_out.out_row     = side_o.row;
  assign sph_out.out_col     = side_o.col;
  assign sph_out.out_blue    = side_o.blue;
  assign sph_out.out_green   = side_o.green;
  assign sph_out.out_red     = side_o.red;

  // ---------------- checks ----------------
  // a live item reaching the root stage has nonzero radius
  a_root_nonzero: assert property (@(posedge clk) disable iff (rst)
    v37 |-> r37 != '0) else $error("zero root on a live item");

  // theta stays within 0..pi
  a_theta_range: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> theta_a >= 0 && theta_a <= PHI_W'(PI_Q20))
    else $error("theta out of range");

  // phi stays within -pi..pi
  a_phi_range: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> phi_a >= -PHI_W'(PI_Q20) && phi_a <= PHI_W'(PI_Q20))
    else $error("phi out of range");

endmodule

`default_nettype wire

// ----- rtl/fps_delay.sv -----
// ---------------------------------------------------------------------------
// fps_delay: shift line
// fixed depth delay that advances with the pipeline enable
// ---------------------------------------------------------------------------
`default_nettype none

module fps_delay import fps_pkg::*; #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] sr [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        sr[i] <= '0;
      end
    end else if (en) begin
      sr[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[DEPTH-1];

endmodule

`default_nettype wire

// ----- rtl/fps_mulsh.sv -----
// ---------------------------------------------------------------------------
// fps_mulsh: pipelined signed 64x64 multiply with shift and saturation
// sign-magnitude, four 32x32 partial products, truncate toward zero
// ---------------------------------------------------------------------------
`default_nettype none

module fps_mulsh import fps_pkg::*; #(
  parameter int SHIFT = 48
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [63:0] a,
  input  wire logic signed [63:0] b,
  output logic signed      [63:0] p
);

  logic        neg1, neg2, neg3;
  logic [63:0] ma, mb;
  logic [63:0] p0, p1, p2, p3;
  logic [127:0] full;
  logic [127:0] shv;
  logic [62:0]  mag_c;

  always_comb begin
    shv   = full >> SHIFT;
    mag_c = (shv[127:63] != '0) ? SAT_MAX[62:0] : shv[62:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: sign and magnitudes
      neg1 <= a[63] ^ b[63];
      ma   <= a[63] ? (~a + 64'd1) : a;
      mb   <= b[63] ? (~b + 64'd1) : b;
      // stage 2: partial products
      neg2 <= neg1;
      p0   <= ma[31:0]  * mb[31:0];
      p1   <= ma[31:0]  * mb[63:32];
      p2   <= ma[63:32] * mb[31:0];
      p3   <= ma[63:32] * mb[63:32];
      // stage 3: full product
      neg3 <= neg2;
      full <= {64'd0, p0} + {32'd0, p1, 32'd0} + {32'd0, p2, 32'd0} + {p3, 64'd0};
      // stage 4: shift, saturate, sign
      p    <= neg3 ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fps_sqrt.sv -----
// ---------------------------------------------------------------------------
// fps_sqrt: pipelined integer square root
// one result bit per stage, floor of the root
// ---------------------------------------------------------------------------
`default_nettype none

module fps_sqrt import fps_pkg::*; (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [R2_W-1:0] r2,
  output logic      [R_W-1:0]  r
);

  localparam int N_W = 2 * R_W;

  logic [N_W-1:0] n_s   [SQRT_STAGES];
  logic [N_W-1:0] res_s [SQRT_STAGES];
  logic [N_W-1:0] n_d   [SQRT_STAGES];
  logic [N_W-1:0] res_d [SQRT_STAGES];
  logic [N_W-1:0] cn, cres, bitv, trial;

  always_comb begin
    for (int k = 0; k < SQRT_STAGES; k++) begin
      if (k == 0) begin
        cn   = N_W'(r2);
        cres = '0;
      end else begin
        cn   = n_s[k-1];
        cres = res_s[k-1];
      end
      bitv  = N_W'(1) << (2 * (SQRT_STAGES - 1 - k));
      trial = cres + bitv;
      if (cn >= trial) begin
        n_d[k]   = cn - trial;
        res_d[k] = (cres >> 1) + bitv;
      end else begin
        n_d[k]   = cn;
        res_d[k] = cres >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
        n_s[k]   <= n_d[k];
        res_s[k] <= res_d[k];
      end
    end
  end

  assign r = res_s[SQRT_STAGES-1][R_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/fps_cordic.sv -----
// ---------------------------------------------------------------------------
// fps_cordic: pipelined atan2 by cordic vectoring
// staged normalize, quadrant fold, 25 rotations, round to q3.20 and clamp
// ---------------------------------------------------------------------------
`default_nettype none

module fps_cordic import fps_pkg::*; #(
  parameter bit SIGNED_OUT = 1'b1
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [63:0] x_in,
  input  wire logic signed [63:0] y_in,
  output logic signed      [PHI_W-1:0] ang
);

  localparam int CW = 44;
  localparam int AW = 28;
  localparam int QW = AW - 4;

  logic signed [63:0] nx [NORM_STEPS];
  logic signed [63:0] ny [NORM_STEPS];
  logic        [63:0] nm [NORM_STEPS];
  logic               nz [NORM_STEPS];
  logic signed [63:0] nx_d [NORM_STEPS];
  logic signed [63:0] ny_d [NORM_STEPS];
  logic        [63:0] nm_d [NORM_STEPS];
  logic               nz_d [NORM_STEPS];

  logic signed [CW-1:0] fx, fy, fx_d, fy_d;
  logic signed [AW-1:0] facc, facc_d;
  logic                 fz;

  logic signed [CW-1:0] cx [CORDIC_STEPS];
  logic signed [CW-1:0] cy [CORDIC_STEPS];
  logic signed [AW-1:0] ca [CORDIC_STEPS];
  logic                 cz [CORDIC_STEPS];
  logic signed [CW-1:0] cx_d [CORDIC_STEPS];
  logic signed [CW-1:0] cy_d [CORDIC_STEPS];
  logic signed [AW-1:0] ca_d [CORDIC_STEPS];
  logic                 cz_d [CORDIC_STEPS];

  logic signed [63:0]   sx, sy;
  logic        [63:0]   sm, mx, my;
  logic                 szf;
  logic signed [CW-1:0] xs, ys, ix, iy, dx, dy;
  logic signed [AW-1:0] ia, tab;
  logic                 iz;
  logic signed [QW-1:0] q, lo;
  logic signed [PHI_W-1:0] ang_d;

  // normalize: larger magnitude into [2^38, 2^39), one shift size per stage
  always_comb begin
    mx = x_in[63] ? (~x_in + 64'd1) : x_in;
    my = y_in[63] ? (~y_in + 64'd1) : y_in;
    for (int j = 0; j < NORM_STEPS; j++) begin
      if (j == 0) begin
        sx  = x_in;
        sy  = y_in;
        sm  = (mx > my) ? mx : my;
        szf = (sm == 64'd0);
      end else begin
        sx  = nx[j-1];
        sy  = ny[j-1];
        sm  = nm[j-1];
        szf = nz[j-1];
      end
      nx_d[j] = sx;
      ny_d[j] = sy;
      nm_d[j] = sm;
      nz_d[j] = szf;
      if ((sm >> (NORM_MSB + (32 >> j))) != 64'd0) begin
        nx_d[j] = sx >>> (32 >> j);
        ny_d[j] = sy >>> (32 >> j);
        nm_d[j] = sm >> (32 >> j);
      end else if ((sm >> (NORM_MSB + 1 - (32 >> j))) == 64'd0) begin
        nx_d[j] = sx <<< (32 >> j);
        ny_d[j] = sy <<< (32 >> j);
        nm_d[j] = sm << (32 >> j);
      end
    end
  end

  // fold the left half plane by +-pi/2
  always_comb begin
    xs = nx[NORM_STEPS-1][CW-1:0];
    ys = ny[NORM_STEPS-1][CW-1:0];
    if (xs < 0) begin
      if (ys >= 0) begin
        fx_d   = ys;
        fy_d   = -xs;
        facc_d = AW'(HALF_PI_Q24);
      end else begin
        fx_d   = -ys;
        fy_d   = xs;
        facc_d = -AW'(HALF_PI_Q24);
      end
    end else begin
      fx_d   = xs;
      fy_d   = ys;
      facc_d = '0;
    end
  end

  // rotation steps
  always_comb begin
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (i == 0) begin
        ix = fx;
        iy = fy;
        ia = facc;
        iz = fz;
      end else begin
        ix = cx[i-1];
        iy = cy[i-1];
        ia = ca[i-1];
        iz = cz[i-1];
      end
      dx  = iy >>> i;
      dy  = ix >>> i;
      tab = $signed({4'b0, ATAN_TAB[i]});
      if (iy > 0) begin
        cx_d[i] = ix + dx;
        cy_d[i] = iy - dy;
        ca_d[i] = ia + tab;
      end else begin
        cx_d[i] = ix - dx;
        cy_d[i] = iy + dy;
        ca_d[i] = ia - tab;
      end
      cz_d[i] = iz;
    end
  end

  // round q.24 to q.20 and clamp
  always_comb begin
    q  = QW'((ca[CORDIC_STEPS-1] + AW'(8)) >>> 4);
    lo = SIGNED_OUT ? -QW'(PI_Q20) : QW'(0);
    if (q > QW'(PI_Q20)) begin
      q = QW'(PI_Q20);
    end
    if (q < lo) begin
      q = lo;
    end
    ang_d = cz[CORDIC_STEPS-1] ? '0 : PHI_W'(q);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NORM_STEPS; j++) begin
        nx[j] <= nx_d[j];
        ny[j] <= ny_d[j];
        nm[j] <= nm_d[j];
        nz[j] <= nz_d[j];
      end
      fx   <= fx_d;
      fy   <= fy_d;
      facc <= facc_d;
      fz   <= nz[NORM_STEPS-1];
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        cx[i] <= cx_d[i];
        cy[i] <= cy_d[i];
        ca[i] <= ca_d[i];
        cz[i] <= cz_d[i];
      end
      ang <= ang_d;
    end
  end

endmodule

`default_nettype wire
